// ===== rtl/qbf_pkg.sv =====
// qbf_pkg: types and constants for the quadratic bezier flattener
// no dependencies; imported by qbf_div and quad_bezier_flattener
package qbf_pkg;

    localparam int COORD_W   = 32;
    localparam int MAX_STEPS = 64;
    localparam int STEP_W    = 7;          // holds 0 .. MAX_STEPS
    localparam int WGT_W     = 13;         // weights and n*n, up to 4096
    localparam int NUM_W     = 46;         // weighted sum plus rounding half
    localparam int ACC_W     = 50;         // also holds the sum of four squares
    localparam int MAG_W     = 44;         // magnitude of the weighted sum
    localparam int DIFF_W    = COORD_W + 1;
    localparam int MUL_A_W   = 33;
    localparam int MUL_B_W   = 24;
    localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
    localparam int SAT_SHIFT = 23;         // offsets this large saturate n
    localparam int ROOT_SHIFT = 34;        // squared Q16.16 to squared units of two
    localparam int ROOT_IN_W = 14;
    localparam int ROOT_BITS = 7;

    localparam logic [1:0] KIND_MOVE   = 2'd0;
    localparam logic [1:0] KIND_LINE   = 2'd1;
    localparam logic [1:0] KIND_CURVE  = 2'd2;
    localparam logic [1:0] KIND_UNUSED = 2'd3;   // behaves as a line

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ,
        ST_ROOT,
        ST_DEN,
        ST_W0,
        ST_W1,
        ST_W2,
        ST_M0,
        ST_M1,
        ST_M2,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_PUT_PT,
        ST_PUT_ORIG
    } qbf_state_t;

endpackage

// ===== rtl/qbf_div.sv =====
// qbf_div: serial floor divider, one quotient bit per cycle
// depends on qbf_pkg
module qbf_div
    import qbf_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic signed [NUM_W-1:0]   dividend,
    input  logic [WGT_W-1:0]          divisor,
    output logic                      done,
    output logic signed [COORD_W-1:0] quotient
);

    localparam int CNT_W = $clog2(MAG_W + 1);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  neg_reg, neg_next;
    logic [MAG_W-1:0]      q_reg, q_next;
    logic [WGT_W:0]        rem_reg, rem_next;
    logic [WGT_W-1:0]      dvs_reg, dvs_next;
    logic [WGT_W:0]        trial;
    logic [NUM_W-1:0]      mag;
    logic [COORD_W-1:0]    qmag;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        q_reg   <= q_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    // restoring step
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        mag       = dividend[NUM_W-1] ? (~dividend + 1'b1) : dividend;
        trial     = {rem_reg[WGT_W-1:0], q_reg[MAG_W-1]};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(MAG_W);
            neg_next  = dividend[NUM_W-1];
            q_next    = mag[MAG_W-1:0];
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = trial - {1'b0, dvs_reg};
                q_next   = {q_reg[MAG_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                q_next   = {q_reg[MAG_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // floor for negative dividends: one further down when a remainder is left
    always_comb
    begin
        qmag = q_reg[COORD_W-1:0];
        if (neg_reg)
            quotient = -$signed(qmag) - ((rem_reg != '0) ? 32'sd1 : 32'sd0);
        else
            quotient = $signed(qmag);
    end

    assign done = done_reg;

endmodule

// ===== rtl/quad_bezier_flattener.sv =====
// quad_bezier_flattener: path point flattener, top level
// depends on qbf_pkg and qbf_div
//
//  channel  dir  tdata (low bit up)                  tuser / tlast
//  s_*      in   end_x, end_y, ctrl_x, ctrl_y        tuser: point_kind
//  m_*      out  out_x, out_y                        tuser: connected, is_original; tlast: last
//
// a line, a move or a first point is accepted, then gives one output word.
// a curve first finds n (four squares, a 7-bit root, skipped when an
// offset saturates n), then n*n; each interpolated point runs the 44-step
// serial divider once per coordinate; one shared multiplier does all products.
// reset clears the previous point; a stalled output holds the sequencer.
module quad_bezier_flattener
    import qbf_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // end_x, end_y, ctrl_x, ctrl_y
    input  logic [1:0]   s_tuser,   // point_kind
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [63:0]  m_tdata,   // out_x, out_y
    output logic [1:0]   m_tuser,   // connected, is_original
    output logic         m_tlast
);

    qbf_state_t state_reg, state_next;
    logic                      pvalid_reg, pvalid_next;
    logic signed [COORD_W-1:0] prevx_reg, prevx_next, prevy_reg, prevy_next;
    logic signed [COORD_W-1:0] p0x_reg, p0x_next, p0y_reg, p0y_next;
    logic signed [COORD_W-1:0] ex_reg, ex_next, ey_reg, ey_next;
    logic signed [COORD_W-1:0] cx_reg, cx_next, cy_reg, cy_next;
    logic signed [COORD_W-1:0] qx_reg, qx_next, qy_reg, qy_next;
    logic [1:0]                kind_reg, kind_next;
    logic [1:0]                idx_reg, idx_next;
    logic                      sat_reg, sat_next;
    logic signed [ACC_W-1:0]   acc_reg, acc_next;
    logic [ROOT_BITS-1:0]      r_reg, r_next;
    logic [2:0]                bit_reg, bit_next;
    logic [STEP_W-1:0]         n_reg, n_next, s_reg, s_next;
    logic [WGT_W-1:0]          den_reg, den_next;
    logic [WGT_W-1:0]          w0_reg, w0_next, w1_reg, w1_next, w2_reg, w2_next;
    logic                      axis_reg, axis_next;

    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] prod;
    logic signed [DIFF_W-1:0]  d;
    logic [DIFF_W-1:0]         ad;
    logic                      big;
    logic [ROOT_BITS-1:0]      trial;
    logic [ROOT_BITS-1:0]      r_cand;
    logic [STEP_W-1:0]         nms;
    logic [STEP_W-1:0]         n_root;
    logic signed [COORD_W-1:0] p0c, cc, p1c;
    logic                      div_start, div_done;
    logic signed [COORD_W-1:0] div_q;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            pvalid_reg <= 1'b0;
            prevx_reg  <= '0;
            prevy_reg  <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            pvalid_reg <= pvalid_next;
            prevx_reg  <= prevx_next;
            prevy_reg  <= prevy_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        p0x_reg  <= p0x_next;
        p0y_reg  <= p0y_next;
        ex_reg   <= ex_next;
        ey_reg   <= ey_next;
        cx_reg   <= cx_next;
        cy_reg   <= cy_next;
        qx_reg   <= qx_next;
        qy_reg   <= qy_next;
        kind_reg <= kind_next;
        idx_reg  <= idx_next;
        sat_reg  <= sat_next;
        acc_reg  <= acc_next;
        r_reg    <= r_next;
        bit_reg  <= bit_next;
        n_reg    <= n_next;
        s_reg    <= s_next;
        den_reg  <= den_next;
        w0_reg   <= w0_next;
        w1_reg   <= w1_next;
        w2_reg   <= w2_next;
        axis_reg <= axis_next;
    end

    // operand selection for the offsets, the root trial and the coordinate terms
    always_comb
    begin
        case (idx_reg)
            2'd0:    d = DIFF_W'(cx_reg) - DIFF_W'(p0x_reg);
            2'd1:    d = DIFF_W'(cy_reg) - DIFF_W'(p0y_reg);
            2'd2:    d = DIFF_W'(cx_reg) - DIFF_W'(ex_reg);
            default: d = DIFF_W'(cy_reg) - DIFF_W'(ey_reg);
        endcase
        ad    = d[DIFF_W-1] ? (~d + 1'b1) : d;
        big   = ad >= (DIFF_W'(1) << SAT_SHIFT);
        trial = r_reg | (ROOT_BITS'(1) << bit_reg);
        nms   = n_reg - s_reg;
        p0c   = axis_reg ? p0y_reg : p0x_reg;
        cc    = axis_reg ? cy_reg : cx_reg;
        p1c   = axis_reg ? ey_reg : ex_reg;
    end

    // shared multiplier
    always_comb
    begin
        case (state_reg)
            ST_SQ:
            begin
                mul_a = MUL_A_W'(d);
                mul_b = d[MUL_B_W-1:0];
            end
            ST_ROOT:
            begin
                mul_a = MUL_A_W'(trial);
                mul_b = MUL_B_W'(trial);
            end
            ST_DEN:
            begin
                mul_a = MUL_A_W'(n_reg);
                mul_b = MUL_B_W'(n_reg);
            end
            ST_W0:
            begin
                mul_a = MUL_A_W'(nms);
                mul_b = MUL_B_W'(nms);
            end
            ST_W1:
            begin
                mul_a = MUL_A_W'({s_reg, 1'b0});
                mul_b = MUL_B_W'(nms);
            end
            ST_W2:
            begin
                mul_a = MUL_A_W'(s_reg);
                mul_b = MUL_B_W'(s_reg);
            end
            ST_M0:
            begin
                mul_a = MUL_A_W'(p0c);
                mul_b = MUL_B_W'(w0_reg);
            end
            ST_M1:
            begin
                mul_a = MUL_A_W'(cc);
                mul_b = MUL_B_W'(w1_reg);
            end
            default:
            begin
                mul_a = MUL_A_W'(p1c);
                mul_b = MUL_B_W'(w2_reg);
            end
        endcase
        prod = mul_a * mul_b;
    end

    // root bit kept when its square fits, result clipped to the step limit
    assign r_cand = (prod <= MUL_P_W'(acc_reg[ROOT_SHIFT +: ROOT_IN_W])) ? trial : r_reg;
    assign n_root = (r_cand > STEP_W'(MAX_STEPS)) ? STEP_W'(MAX_STEPS) : r_cand;

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        pvalid_next = pvalid_reg;
        prevx_next  = prevx_reg;
        prevy_next  = prevy_reg;
        p0x_next    = p0x_reg;
        p0y_next    = p0y_reg;
        ex_next     = ex_reg;
        ey_next     = ey_reg;
        cx_next     = cx_reg;
        cy_next     = cy_reg;
        qx_next     = qx_reg;
        qy_next     = qy_reg;
        kind_next   = kind_reg;
        idx_next    = idx_reg;
        sat_next    = sat_reg;
        acc_next    = acc_reg;
        r_next      = r_reg;
        bit_next    = bit_reg;
        n_next      = n_reg;
        s_next      = s_reg;
        den_next    = den_reg;
        w0_next     = w0_reg;
        w1_next     = w1_reg;
        w2_next     = w2_reg;
        axis_next   = axis_reg;
        div_start   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    ex_next     = s_tdata[31:0];
                    ey_next     = s_tdata[63:32];
                    cx_next     = s_tdata[95:64];
                    cy_next     = s_tdata[127:96];
                    kind_next   = s_tuser;
                    p0x_next    = prevx_reg;
                    p0y_next    = prevy_reg;
                    prevx_next  = s_tdata[31:0];
                    prevy_next  = s_tdata[63:32];
                    pvalid_next = 1'b1;
                    idx_next    = 2'd0;
                    sat_next    = 1'b0;
                    acc_next    = '0;
                    if (s_tuser == KIND_CURVE && pvalid_reg)
                        state_next = ST_SQ;
                    else
                        state_next = ST_PUT_ORIG;
                end
            end
            ST_SQ:
            begin
                sat_next = sat_reg | big;
                acc_next = acc_reg + ACC_W'(prod);
                idx_next = idx_reg + 1'b1;
                if (idx_reg == 2'd3)
                begin
                    if (sat_next)
                    begin
                        n_next     = STEP_W'(MAX_STEPS);
                        state_next = ST_DEN;
                    end
                    else
                    begin
                        r_next     = '0;
                        bit_next   = 3'(ROOT_BITS - 1);
                        state_next = ST_ROOT;
                    end
                end
            end
            ST_ROOT:
            begin
                r_next   = r_cand;
                bit_next = bit_reg - 1'b1;
                if (bit_reg == 3'd0)
                begin
                    n_next = n_root;
                    if (n_root < STEP_W'(2))
                        state_next = ST_PUT_ORIG;
                    else
                        state_next = ST_DEN;
                end
            end
            ST_DEN:
            begin
                den_next   = prod[WGT_W-1:0];
                s_next     = STEP_W'(1);
                state_next = ST_W0;
            end
            ST_W0:
            begin
                w0_next    = prod[WGT_W-1:0];
                state_next = ST_W1;
            end
            ST_W1:
            begin
                w1_next    = prod[WGT_W-1:0];
                state_next = ST_W2;
            end
            ST_W2:
            begin
                w2_next    = prod[WGT_W-1:0];
                axis_next  = 1'b0;
                state_next = ST_M0;
            end
            // weighted sum plus half the divisor, one term a cycle
            ST_M0:
            begin
                acc_next   = ACC_W'(prod) + ACC_W'(den_reg >> 1);
                state_next = ST_M1;
            end
            ST_M1:
            begin
                acc_next   = acc_reg + ACC_W'(prod);
                state_next = ST_M2;
            end
            ST_M2:
            begin
                acc_next   = acc_reg + ACC_W'(prod);
                state_next = ST_DIV_START;
            end
            ST_DIV_START:
            begin
                div_start  = 1'b1;
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    if (!axis_reg)
                    begin
                        qx_next    = div_q;
                        axis_next  = 1'b1;
                        state_next = ST_M0;
                    end
                    else
                    begin
                        qy_next    = div_q;
                        state_next = ST_PUT_PT;
                    end
                end
            end
            ST_PUT_PT:
            begin
                if (m_tready)
                begin
                    if (s_reg == n_reg - 1'b1)
                        state_next = ST_PUT_ORIG;
                    else
                    begin
                        s_next     = s_reg + 1'b1;
                        state_next = ST_W0;
                    end
                end
            end
            ST_PUT_ORIG:
            begin
                if (m_tready)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    qbf_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (acc_reg[NUM_W-1:0]),
        .divisor  (den_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    // output word, held in the registered state until taken
    always_comb
    begin
        s_tready = (state_reg == ST_IDLE);
        m_tvalid = (state_reg == ST_PUT_PT) || (state_reg == ST_PUT_ORIG);
        m_tlast  = (state_reg == ST_PUT_ORIG);
        if (state_reg == ST_PUT_ORIG)
        begin
            m_tdata = {ey_reg, ex_reg};
            m_tuser = {1'b1, kind_reg != KIND_MOVE};
        end
        else
        begin
            m_tdata = {qy_reg, qx_reg};
            m_tuser = 2'b01;
        end
    end

endmodule
